@@ rtl/crhp_pkg.sv @@
// Shared types and constants for the capture record header parser.
package crhp_pkg;

   // Header field tags
   localparam logic [15:0] TAG_LENGTH  = 16'h0000;
   localparam logic [15:0] TAG_TS_LOW  = 16'h0001;
   localparam logic [15:0] TAG_TS_HIGH = 16'h0002;
   localparam logic [15:0] TAG_CHANNEL = 16'h0004;
   localparam logic [15:0] TAG_RATE    = 16'h0005;
   localparam logic [15:0] TAG_SIGNAL  = 16'h0006;
   localparam logic [15:0] TAG_END     = 16'hFFFF;

   // Configuration register indexes (paddr[2])
   localparam logic REG_MEDIA_SUBTYPE      = 1'b0;
   localparam logic REG_MAX_CAPTURE_LENGTH = 1'b1;

   localparam logic [1:0]  SUBTYPE_ETHERNET     = 2'd0;
   localparam logic [1:0]  SUBTYPE_WIRELESS_A   = 2'd1;
   localparam logic [1:0]  SUBTYPE_WIRELESS_B   = 2'd2;
   localparam logic [1:0]  SUBTYPE_WIRELESS_FCS = 2'd3;
   localparam logic [31:0] MAX_CAPTURE_RESET    = 32'd65535;
   localparam logic [2:0]  FCS_BYTES            = 3'd4;
   localparam logic [15:0] FIELD_BYTES          = 16'd6;

   // Timestamp split: 64-bit ns count / 1e9, quotient fits 35 bits
   localparam int          REM_BITS   = 30;
   localparam int          QUOT_BITS  = 35;
   localparam int          CHUNK_BITS = 5;
   localparam int          DIV_STAGES = QUOT_BITS / CHUNK_BITS;
   localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
   localparam logic [34:0] EPOCH_SHIFT_SECONDS = 35'd11644473600;

   typedef enum logic [2:0] {
      ST_OK,
      ST_DUP_LENGTH,
      ST_DUP_TS_LOW,
      ST_DUP_TS_HIGH,
      ST_MISS_LENGTH,
      ST_MISS_TS_LOW,
      ST_MISS_TS_HIGH,
      ST_TOO_LARGE
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] orig_length;
      logic [31:0] capture_length;
      logic [63:0] ts_ns;
      logic [31:0] channel_number;
      logic [31:0] link_rate;
      logic [31:0] signal_strength;
      logic [2:0]  fcs_length;
      logic [15:0] header_bytes;
   } job_type;

endpackage

@@ rtl/capture_record_header_parser_unit.sv @@
// Capture record header parser: top level with configuration registers.
//
// Input channel (req_*): one header field per transfer, a 16-bit tag and its
// 32-bit value. Tags for length, timestamp halves, channel, rate and signal
// are collected; tag 0xFFFF ends the record. A repeated length or timestamp
// tag ends the record at once with an error result.
// Result channel (rsp_*): one transfer per record end or error, carrying status,
// trimmed lengths, Unix seconds/nanoseconds and the radio words.
// Configuration: APB-style; media_subtype at 0x0, max_capture_length at 0x4.
// Throughput: one input transfer per cycle while req_ready is high. From the accepted ending
// transfer to rsp_valid, a job passes through the job queue, then the 7-stage
// divide pipeline (5 quotient bits per stage) and then the result register.
// A stalled rsp_ready freezes the divide pipeline; the job queue (QUEUE_DEPTH
// entries) keeps taking input until it fills, then req_ready drops.
// Reset clears the record state, the queue and the pipeline; media_subtype
// returns to 0 and max_capture_length to 65535.
module capture_record_header_parser_unit import crhp_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_record_tag,
   input  logic [31:0]        req_record_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [31:0]        rsp_orig_length,
   output logic [31:0]        rsp_capture_length,
   output logic signed [34:0] rsp_ts_seconds,
   output logic [29:0]        rsp_ts_nanoseconds,
   output logic [31:0]        rsp_channel_number,
   output logic [31:0]        rsp_link_rate,
   output logic [31:0]        rsp_signal_strength,
   output logic [2:0]         rsp_fcs_length,
   output logic [15:0]        rsp_header_bytes,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [1:0]  media_subtype_ff;
   logic [31:0] max_capture_length_ff;
   logic        csr_write;

   logic        queue_full;
   logic        accept;
   logic        push;
   job_type     push_job;
   logic        head_valid;
   logic        head_pop;
   job_type     head_job;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         media_subtype_ff      <= '0;
         max_capture_length_ff <= MAX_CAPTURE_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            REG_MEDIA_SUBTYPE:      media_subtype_ff      <= pwdata[1:0];
            REG_MAX_CAPTURE_LENGTH: max_capture_length_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_MEDIA_SUBTYPE:      prdata = {30'd0, media_subtype_ff};
         REG_MAX_CAPTURE_LENGTH: prdata = max_capture_length_ff;
         default:                prdata = '0;
      endcase
   end

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   crhp_front u_front (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .record_tag         (req_record_tag),
      .record_value       (req_record_value),
      .media_subtype      (media_subtype_ff),
      .max_capture_length (max_capture_length_ff),
      .push               (push),
      .push_job           (push_job)
   );

   crhp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   crhp_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head_valid          (head_valid),
      .head_job            (head_job),
      .head_pop            (head_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_orig_length     (rsp_orig_length),
      .rsp_capture_length  (rsp_capture_length),
      .rsp_ts_seconds      (rsp_ts_seconds),
      .rsp_ts_nanoseconds  (rsp_ts_nanoseconds),
      .rsp_channel_number  (rsp_channel_number),
      .rsp_link_rate       (rsp_link_rate),
      .rsp_signal_strength (rsp_signal_strength),
      .rsp_fcs_length      (rsp_fcs_length),
      .rsp_header_bytes    (rsp_header_bytes)
   );

endmodule

@@ rtl/crhp_front.sv @@
// Front end: collects header fields of a record and builds a job at record end or error.
module crhp_front import crhp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [15:0] record_tag,
   input  logic [31:0] record_value,
   input  logic [1:0]  media_subtype,
   input  logic [31:0] max_capture_length,
   output logic        push,
   output job_type     push_job
);

   logic        seen_len_ff, seen_len_in;
   logic        seen_ts_low_ff, seen_ts_low_in;
   logic        seen_ts_high_ff, seen_ts_high_in;
   logic [31:0] pkt_length_ff, pkt_length_in;
   logic [31:0] ts_low_ff, ts_low_in;
   logic [31:0] ts_high_ff, ts_high_in;
   logic [31:0] channel_ff, channel_in;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] signal_ff, signal_in;
   logic [15:0] byte_count_ff, byte_count_in;

   logic        emit;
   status_type  status;
   logic [31:0] slice;
   logic        fcs;

   always_comb begin
      seen_len_in     = seen_len_ff;
      seen_ts_low_in  = seen_ts_low_ff;
      seen_ts_high_in = seen_ts_high_ff;
      pkt_length_in   = pkt_length_ff;
      ts_low_in       = ts_low_ff;
      ts_high_in      = ts_high_ff;
      channel_in      = channel_ff;
      rate_in         = rate_ff;
      signal_in       = signal_ff;
      byte_count_in   = (byte_count_ff > (16'hFFFF - FIELD_BYTES)) ? 16'hFFFF
                        : byte_count_ff + FIELD_BYTES;
      emit   = 1'b0;
      status = ST_OK;
      slice  = (record_value == 32'd0) ? pkt_length_ff : record_value;
      fcs    = (media_subtype == SUBTYPE_WIRELESS_FCS);

      case (record_tag)
         TAG_LENGTH: begin
            if (seen_len_ff) begin
               emit   = 1'b1;
               status = ST_DUP_LENGTH;
            end else begin
               seen_len_in   = 1'b1;
               pkt_length_in = record_value;
            end
         end
         TAG_TS_LOW: begin
            if (seen_ts_low_ff) begin
               emit   = 1'b1;
               status = ST_DUP_TS_LOW;
            end else begin
               seen_ts_low_in = 1'b1;
               ts_low_in      = record_value;
            end
         end
         TAG_TS_HIGH: begin
            if (seen_ts_high_ff) begin
               emit   = 1'b1;
               status = ST_DUP_TS_HIGH;
            end else begin
               seen_ts_high_in = 1'b1;
               ts_high_in      = record_value;
            end
         end
         TAG_CHANNEL: channel_in = record_value;
         TAG_RATE:    rate_in    = record_value;
         TAG_SIGNAL:  signal_in  = record_value;
         TAG_END: begin
            emit = 1'b1;
            if (!seen_len_ff)                   status = ST_MISS_LENGTH;
            else if (!seen_ts_low_ff)           status = ST_MISS_TS_LOW;
            else if (!seen_ts_high_ff)          status = ST_MISS_TS_HIGH;
            else if (slice > max_capture_length) status = ST_TOO_LARGE;
            else                                status = ST_OK;
         end
         default: ;
      endcase

      push_job        = '0;
      push_job.status = status;
      if (status == ST_OK) begin
         push_job.orig_length     = fcs ? pkt_length_ff
                                    : ((pkt_length_ff >= 32'd4) ? pkt_length_ff - 32'd4 : 32'd0);
         push_job.capture_length  = fcs ? slice
                                    : ((slice >= 32'd4) ? slice - 32'd4 : 32'd0);
         push_job.ts_ns           = {ts_high_ff, ts_low_ff};
         push_job.channel_number  = channel_ff;
         push_job.link_rate       = rate_ff;
         push_job.signal_strength = signal_ff;
         push_job.fcs_length      = fcs ? FCS_BYTES : 3'd0;
         push_job.header_bytes    = byte_count_in;
      end

      // any result closes the record
      if (emit) begin
         seen_len_in     = 1'b0;
         seen_ts_low_in  = 1'b0;
         seen_ts_high_in = 1'b0;
         pkt_length_in   = '0;
         ts_low_in       = '0;
         ts_high_in      = '0;
         channel_in      = '0;
         rate_in         = '0;
         signal_in       = '0;
         byte_count_in   = '0;
      end
   end

   assign push = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_len_ff     <= 1'b0;
         seen_ts_low_ff  <= 1'b0;
         seen_ts_high_ff <= 1'b0;
         pkt_length_ff   <= '0;
         ts_low_ff       <= '0;
         ts_high_ff      <= '0;
         channel_ff      <= '0;
         rate_ff         <= '0;
         signal_ff       <= '0;
         byte_count_ff   <= '0;
      end else if (accept) begin
         seen_len_ff     <= seen_len_in;
         seen_ts_low_ff  <= seen_ts_low_in;
         seen_ts_high_ff <= seen_ts_high_in;
         pkt_length_ff   <= pkt_length_in;
         ts_low_ff       <= ts_low_in;
         ts_high_ff      <= ts_high_in;
         channel_ff      <= channel_in;
         rate_ff         <= rate_in;
         signal_ff       <= signal_in;
         byte_count_ff   <= byte_count_in;
      end
   end

endmodule

@@ rtl/crhp_queue.sv @@
// Job queue between the front end and the timestamp back end.
module crhp_queue import crhp_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ rtl/crhp_back.sv @@
// Back end: pipelined split of the ns timestamp into seconds and nanoseconds, result register.
module crhp_back import crhp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  job_type            head_job,
   output logic               head_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [31:0]        rsp_orig_length,
   output logic [31:0]        rsp_capture_length,
   output logic signed [34:0] rsp_ts_seconds,
   output logic [29:0]        rsp_ts_nanoseconds,
   output logic [31:0]        rsp_channel_number,
   output logic [31:0]        rsp_link_rate,
   output logic [31:0]        rsp_signal_strength,
   output logic [2:0]         rsp_fcs_length,
   output logic [15:0]        rsp_header_bytes
);

   typedef struct packed {
      job_type                job;
      logic [REM_BITS-1:0]    rem;
      logic [QUOT_BITS-1:0]   work;   // dividend bits shift out, quotient bits shift in
   } div_stage_type;

   // restoring division, CHUNK_BITS quotient bits per stage
   function automatic div_stage_type div_chunk(input div_stage_type cur);
      div_stage_type     nxt;
      logic [REM_BITS:0] trial;
      logic              qbit;
      nxt = cur;
      for (int i = 0; i < CHUNK_BITS; i++) begin
         trial = {nxt.rem, nxt.work[QUOT_BITS-1]};
         qbit  = (trial >= {1'b0, NS_PER_SEC});
         if (qbit) begin
            nxt.rem = REM_BITS'(trial - {1'b0, NS_PER_SEC});
         end else begin
            nxt.rem = trial[REM_BITS-1:0];
         end
         nxt.work = {nxt.work[QUOT_BITS-2:0], qbit};
      end
      return nxt;
   endfunction

   div_stage_type              load;
   div_stage_type              stage_ff [DIV_STAGES];
   div_stage_type              stage_in [DIV_STAGES];
   logic [DIV_STAGES-1:0]      stage_valid_ff;
   logic                       advance;

   logic                       rsp_valid_ff;
   job_type                    rsp_job_ff;
   logic signed [34:0]         rsp_secs_ff;
   logic [29:0]                rsp_nanos_ff;
   div_stage_type              last;

   assign advance  = !rsp_valid_ff || rsp_ready;
   assign head_pop = advance && head_valid;
   assign last     = stage_ff[DIV_STAGES-1];

   always_comb begin
      // top dividend bits are below the divisor, so they seed the remainder directly
      load.job  = head_job;
      load.rem  = {1'b0, head_job.ts_ns[63:QUOT_BITS]};
      load.work = head_job.ts_ns[QUOT_BITS-1:0];
      stage_in[0] = div_chunk(load);
      for (int s = 1; s < DIV_STAGES; s++) begin
         stage_in[s] = div_chunk(stage_ff[s-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else if (advance) begin
         stage_valid_ff <= {stage_valid_ff[DIV_STAGES-2:0], head_valid};
         rsp_valid_ff   <= stage_valid_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            stage_ff[s] <= stage_in[s];
         end
         rsp_job_ff <= last.job;
         if (last.job.status == ST_OK) begin
            rsp_secs_ff  <= last.work - EPOCH_SHIFT_SECONDS;
            rsp_nanos_ff <= last.rem;
         end else begin
            rsp_secs_ff  <= '0;
            rsp_nanos_ff <= '0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_job_ff.status;
   assign rsp_orig_length     = rsp_job_ff.orig_length;
   assign rsp_capture_length  = rsp_job_ff.capture_length;
   assign rsp_ts_seconds      = rsp_secs_ff;
   assign rsp_ts_nanoseconds  = rsp_nanos_ff;
   assign rsp_channel_number  = rsp_job_ff.channel_number;
   assign rsp_link_rate       = rsp_job_ff.link_rate;
   assign rsp_signal_strength = rsp_job_ff.signal_strength;
   assign rsp_fcs_length      = rsp_job_ff.fcs_length;
   assign rsp_header_bytes    = rsp_job_ff.header_bytes;

`ifndef SYNTH
   a_nanos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_nanos_ff < NS_PER_SEC))
      else $error("nanosecond remainder out of range");

   a_error_zeroed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_job_ff.status != ST_OK) |->
      (rsp_secs_ff == '0 && rsp_nanos_ff == '0 && rsp_job_ff.orig_length == '0
       && rsp_job_ff.header_bytes == '0))
      else $error("error result carries nonzero fields");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(stage_valid_ff))
      else $error("division pipeline moved while output stalled");
`endif

endmodule

@@ tb/capture_record_header_parser_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the capture record header parser unit.
module capture_record_header_parser_unit_tb import crhp_pkg::*; ();

   typedef struct packed {
      status_type  status;
      logic [31:0] orig_length;
      logic [31:0] capture_length;
      logic [34:0] ts_seconds;
      logic [29:0] ts_nanoseconds;
      logic [31:0] channel_number;
      logic [31:0] link_rate;
      logic [31:0] signal_strength;
      logic [2:0]  fcs_length;
      logic [15:0] header_bytes;
   } record_result_type;

   typedef struct {
      logic [15:0] tag;
      logic [31:0] value;
   } header_field_type;

   localparam logic [63:0] NS_IN_SECOND   = 64'd1000000000;
   localparam logic [34:0] SECONDS_TO_1970 = 35'd11644473600;
   localparam int          RANDOM_FIELDS   = 190;

   // Tracks the open record and holds the parsed records still to come out.
   class record_board_type;
      logic [1:0]        subtype;
      logic [31:0]       max_len;
      bit                have_len, have_ts_low, have_ts_high;
      logic [31:0]       pkt_len, ts_low, ts_high, chan, rate, sig_word;
      logic [15:0]       hdr_count;
      record_result_type expected_records[$];
      int                mismatches;

      function new();
         subtype    = '0;
         max_len    = MAX_CAPTURE_RESET;
         mismatches = 0;
         clear();
      endfunction

      function void clear();
         have_len     = 0;
         have_ts_low  = 0;
         have_ts_high = 0;
         pkt_len      = '0;
         ts_low       = '0;
         ts_high      = '0;
         chan         = '0;
         rate         = '0;
         sig_word     = '0;
         hdr_count    = '0;
      endfunction

      function int pending();
         return expected_records.size();
      endfunction

      task report(string msg);
         mismatches++;
         $display("mismatch at %0t: %s", $time, msg);
      endtask

      function logic [31:0] less_fcs(logic [31:0] v);
         return (v >= 32'd4) ? v - 32'd4 : 32'd0;
      endfunction

      function void emit(record_result_type r);
         expected_records.push_back(r);
         clear();
      endfunction

      function void emit_error(status_type st);
         record_result_type r;
         r = '0;
         r.status = st;
         emit(r);
      endfunction

      // Accepted input transfer: update the record, maybe close it.
      function void absorb_field(logic [15:0] tag, logic [31:0] value);
         logic [16:0]       sum;
         logic [31:0]       slice;
         logic [63:0]       ns, quot, rem_ns;
         bit                fcs;
         record_result_type r;
         sum       = {1'b0, hdr_count} + {1'b0, FIELD_BYTES};
         hdr_count = sum[16] ? 16'hFFFF : sum[15:0];
         case (tag)
            TAG_LENGTH: begin
               if (have_len) emit_error(ST_DUP_LENGTH);
               else begin
                  pkt_len  = value;
                  have_len = 1;
               end
            end
            TAG_TS_LOW: begin
               if (have_ts_low) emit_error(ST_DUP_TS_LOW);
               else begin
                  ts_low      = value;
                  have_ts_low = 1;
               end
            end
            TAG_TS_HIGH: begin
               if (have_ts_high) emit_error(ST_DUP_TS_HIGH);
               else begin
                  ts_high      = value;
                  have_ts_high = 1;
               end
            end
            TAG_CHANNEL: chan = value;
            TAG_RATE:    rate = value;
            TAG_SIGNAL:  sig_word = value;
            TAG_END: begin
               slice = (value == 32'd0) ? pkt_len : value;
               if (!have_len) emit_error(ST_MISS_LENGTH);
               else if (!have_ts_low) emit_error(ST_MISS_TS_LOW);
               else if (!have_ts_high) emit_error(ST_MISS_TS_HIGH);
               else if (slice > max_len) emit_error(ST_TOO_LARGE);
               else begin
                  fcs    = (subtype == SUBTYPE_WIRELESS_FCS);
                  ns     = {ts_high, ts_low};
                  quot   = ns / NS_IN_SECOND;
                  rem_ns = ns % NS_IN_SECOND;
                  r = '0;
                  r.status          = ST_OK;
                  r.orig_length     = fcs ? pkt_len : less_fcs(pkt_len);
                  r.capture_length  = fcs ? slice : less_fcs(slice);
                  r.ts_seconds      = quot[34:0] - SECONDS_TO_1970;
                  r.ts_nanoseconds  = rem_ns[29:0];
                  r.channel_number  = chan;
                  r.link_rate       = rate;
                  r.signal_strength = sig_word;
                  r.fcs_length      = fcs ? FCS_BYTES : 3'd0;
                  r.header_bytes    = hdr_count;
                  emit(r);
               end
            end
            default: ;
         endcase
      endfunction

      task compare(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report($sformatf("%s got %0h expected %0h", name, got, want));
      endtask

      task check_record(record_result_type got);
         record_result_type want;
         if (expected_records.size() == 0) begin
            report("result transfer with no record pending");
            return;
         end
         want = expected_records.pop_front();
         compare("status", got.status, want.status);
         compare("orig_length", got.orig_length, want.orig_length);
         compare("capture_length", got.capture_length, want.capture_length);
         compare("ts_seconds", got.ts_seconds, want.ts_seconds);
         compare("ts_nanoseconds", got.ts_nanoseconds, want.ts_nanoseconds);
         compare("channel_number", got.channel_number, want.channel_number);
         compare("link_rate", got.link_rate, want.link_rate);
         compare("signal_strength", got.signal_strength, want.signal_strength);
         compare("fcs_length", got.fcs_length, want.fcs_length);
         compare("header_bytes", got.header_bytes, want.header_bytes);
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [15:0]        req_record_tag = '0;
   logic [31:0]        req_record_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_status;
   logic [31:0]        rsp_orig_length;
   logic [31:0]        rsp_capture_length;
   logic signed [34:0] rsp_ts_seconds;
   logic [29:0]        rsp_ts_nanoseconds;
   logic [31:0]        rsp_channel_number;
   logic [31:0]        rsp_link_rate;
   logic [31:0]        rsp_signal_strength;
   logic [2:0]         rsp_fcs_length;
   logic [15:0]        rsp_header_bytes;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   record_board_type board;
   int               burst_left = 0;
   int               fields_sent = 0;
   int               stall_left = 0;
   int               ready_pct = 100;

   capture_record_header_parser_unit dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Result side: check each transfer, stall on a pattern that changes now and then.
   always @(posedge clock) begin
      record_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.status          = status_type'(rsp_status);
         got.orig_length     = rsp_orig_length;
         got.capture_length  = rsp_capture_length;
         got.ts_seconds      = rsp_ts_seconds;
         got.ts_nanoseconds  = rsp_ts_nanoseconds;
         got.channel_number  = rsp_channel_number;
         got.link_rate       = rsp_link_rate;
         got.signal_strength = rsp_signal_strength;
         got.fcs_length      = rsp_fcs_length;
         got.header_bytes    = rsp_header_bytes;
         board.check_record(got);
      end
      if (stall_left == 0) begin
         stall_left = $urandom_range(10, 90);
         case ($urandom_range(0, 4))
            0, 1:    ready_pct = 100;
            2:       ready_pct = 70;
            3:       ready_pct = 35;
            default: ready_pct = 5;
         endcase
      end else begin
         stall_left--;
      end
      rsp_ready <= ($urandom_range(1, 100) <= ready_pct);
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   // Called just after a rising edge; returns at the edge that takes the transfer.
   task automatic send_field(input logic [15:0] tag, input logic [31:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 16);
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_record_tag   <= tag;
      req_record_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.absorb_field(tag, value);
      if (tag inside {TAG_LENGTH, TAG_TS_LOW, TAG_TS_HIGH, TAG_CHANNEL, TAG_RATE,
                      TAG_SIGNAL, TAG_END})
         fields_sent++;
   endtask

   task automatic write_register(input logic reg_sel, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_register(input logic reg_sel, output logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {reg_sel, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      data = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [1:0] subtype, input logic [31:0] max_len);
      logic [31:0] data;
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      data      = $urandom;
      data[1:0] = subtype;
      write_register(REG_MEDIA_SUBTYPE, data);
      board.subtype = subtype;
      write_register(REG_MAX_CAPTURE_LENGTH, max_len);
      board.max_len = max_len;
      read_register(REG_MEDIA_SUBTYPE, data);
      if (data !== {30'd0, subtype})
         board.report($sformatf("media_subtype read %0h", data));
      read_register(REG_MAX_CAPTURE_LENGTH, data);
      if (data !== max_len)
         board.report($sformatf("max_capture_length read %0h", data));
   endtask

   function automatic header_field_type field_of(logic [15:0] tag, logic [31:0] value);
      header_field_type f;
      f.tag   = tag;
      f.value = value;
      return f;
   endfunction

   function automatic logic [31:0] pick_length();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 7);
         1:       return board.max_len + $urandom_range(0, 2) - 1;
         2:       return $urandom;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom_range(4, 2000);
      endcase
   endfunction

   function automatic logic [31:0] pick_slice(logic [31:0] len);
      case ($urandom_range(0, 4))
         0, 1:    return 32'd0;
         2:       return len;
         default: return pick_length();
      endcase
   endfunction

   function automatic logic [31:0] pick_ts_low();
      case ($urandom_range(0, 5))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'hD53E_8000;
         default: return $urandom;
      endcase
   endfunction

   // Includes the high word of 0x019DB1DE_D53E8000, which as a ns count lies well before 1970.
   function automatic logic [31:0] pick_ts_high();
      case ($urandom_range(0, 5))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h019D_B1DE;
         3, 4:    return $urandom_range(32'h01D0_0000, 32'h01E0_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_radio_tag();
      case ($urandom_range(0, 2))
         0:       return TAG_CHANNEL;
         1:       return TAG_RATE;
         default: return TAG_SIGNAL;
      endcase
   endfunction

   function automatic logic [15:0] pick_unknown_tag();
      logic [15:0] t;
      t = 16'($urandom_range(0, 16'hFFFE));
      if (t inside {TAG_LENGTH, TAG_TS_LOW, TAG_TS_HIGH, TAG_CHANNEL, TAG_RATE, TAG_SIGNAL})
         t = 16'h0003;
      return t;
   endfunction

   // Mostly complete records in random field order; some missing, duplicated or noise.
   task automatic send_random_record();
      header_field_type fields[$];
      header_field_type f;
      logic [31:0]      len;
      int               kind, i, j;
      kind = $urandom_range(0, 99);
      if (kind >= 90) begin
         repeat ($urandom_range(1, 4)) send_field(16'($urandom_range(0, 16'hFFFF)), $urandom);
         return;
      end
      len = pick_length();
      fields.push_back(field_of(TAG_LENGTH, len));
      fields.push_back(field_of(TAG_TS_LOW, pick_ts_low()));
      fields.push_back(field_of(TAG_TS_HIGH, pick_ts_high()));
      if (kind >= 70 && kind < 80) begin
         fields.delete($urandom_range(0, 2));
         if ($urandom_range(0, 1)) fields.delete($urandom_range(0, 1));
      end
      repeat ($urandom_range(0, 3)) fields.push_back(field_of(pick_radio_tag(), $urandom));
      if ($urandom_range(0, 3) == 0) fields.push_back(field_of(pick_unknown_tag(), $urandom));
      for (i = fields.size() - 1; i > 0; i--) begin
         j         = $urandom_range(0, i);
         f         = fields[i];
         fields[i] = fields[j];
         fields[j] = f;
      end
      foreach (fields[k]) send_field(fields[k].tag, fields[k].value);
      if (kind >= 80 && kind < 90) begin
         case ($urandom_range(0, 2))
            0:       send_field(TAG_LENGTH, $urandom);
            1:       send_field(TAG_TS_LOW, $urandom);
            default: send_field(TAG_TS_HIGH, $urandom);
         endcase
      end else begin
         send_field(TAG_END, pick_slice(len));
      end
   endtask

   task automatic run_random_records();
      int stop_at;
      stop_at = fields_sent + RANDOM_FIELDS;
      while (fields_sent < stop_at) send_random_record();
   endtask

   // One long record packed with radio and unknown fields.
   task automatic send_long_record();
      send_field(TAG_LENGTH, $urandom_range(0, 1500));
      send_field(TAG_TS_LOW, $urandom);
      send_field(TAG_TS_HIGH, pick_ts_high());
      repeat (40) begin
         if ($urandom_range(0, 3) == 0) send_field(pick_unknown_tag(), $urandom);
         else send_field(pick_radio_tag(), $urandom);
      end
      send_field(TAG_END, 32'd0);
   endtask

   initial begin
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed records under the reset configuration.
      send_field(TAG_END, 32'd0);                   // all three missing
      send_field(TAG_LENGTH, 32'd64);
      send_field(TAG_END, 32'd0);                   // timestamp low missing
      send_field(TAG_LENGTH, 32'd64);
      send_field(TAG_TS_LOW, 32'h1234_5678);
      send_field(TAG_END, 32'd0);                   // timestamp high missing
      send_field(TAG_LENGTH, 32'd10);
      send_field(TAG_LENGTH, 32'd20);
      send_field(TAG_TS_LOW, 32'd1);
      send_field(TAG_TS_LOW, 32'd2);
      send_field(TAG_TS_HIGH, 32'd1);
      send_field(TAG_TS_HIGH, 32'd2);
      send_field(TAG_LENGTH, MAX_CAPTURE_RESET);    // at the limit, zero timestamp
      send_field(TAG_TS_LOW, 32'd0);
      send_field(TAG_TS_HIGH, 32'd0);
      send_field(TAG_END, 32'd0);
      send_field(TAG_LENGTH, 32'd3);                // trims to zero, largest timestamp
      send_field(TAG_TS_LOW, 32'hFFFF_FFFF);
      send_field(TAG_TS_HIGH, 32'hFFFF_FFFF);
      send_field(TAG_CHANNEL, 32'hFFFF_FFFF);
      send_field(TAG_RATE, 32'hAAAA_5555);
      send_field(TAG_SIGNAL, 32'h5555_AAAA);
      send_field(TAG_END, 32'd0);
      send_field(TAG_LENGTH, 32'd100);              // slice above limit
      send_field(TAG_TS_LOW, 32'hD53E_8000);
      send_field(TAG_TS_HIGH, 32'h019D_B1DE);
      send_field(TAG_END, MAX_CAPTURE_RESET + 32'd1);

      apply_setting(SUBTYPE_WIRELESS_A, 32'hFFFF_FFFF);
      run_random_records();
      apply_setting(SUBTYPE_WIRELESS_FCS, 32'd0);
      run_random_records();
      apply_setting(SUBTYPE_WIRELESS_B, $urandom);
      run_random_records();
      apply_setting(SUBTYPE_WIRELESS_FCS, 32'hFFFF_FFFF);
      run_random_records();
      apply_setting(SUBTYPE_ETHERNET, $urandom_range(1500, 4000));
      run_random_records();
      send_long_record();

      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.pending() != 0)
         board.report("records still pending at end");
      if (board.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
